>>> hdl/largest_digit_subsequence_assert.svh
// Assertion macros for the largest digit subsequence checker
`ifndef LARGEST_DIGIT_SUBSEQUENCE_ASSERT_SVH
`define LARGEST_DIGIT_SUBSEQUENCE_ASSERT_SVH

// clocked assertion, quiet while reset is held
`define LDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also checks across the reset cycle
`define LDS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/lds_pkg.sv
// Types, constants and helpers shared by the largest digit subsequence block
`timescale 1ns / 1ps

package lds_pkg;

  localparam int DIGIT_W        = 4;
  localparam int KEEP_W         = 4;
  localparam int VALUE_W        = 40;
  localparam int TOTAL_W        = 48;
  localparam int LINE_DEPTH_DEF = 128;
  localparam int MAX_KEEP_DEF   = 12;

  localparam logic [KEEP_W-1:0]  KEEP_RESET = 4'd12;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last_digit;
  } lds_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] best_value;
    logic [TOTAL_W-1:0] running_total;
    logic               line_overflow;
  } lds_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_SCAN,
    ST_DRAIN,
    ST_ACC,
    ST_DONE
  } lds_state_t;

  // bits needed to hold any number of n decimal digits
  function automatic int dec_bits(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return $clog2(p);
  endfunction

endpackage

>>> hdl/largest_digit_subsequence.sv
// Largest in-order keep_count-digit number from a buffered line of digits
// Throughput: digits not last in a line are taken one per cycle while no selection runs.
// Selection: after the last digit is taken, each kept position goes through POS, SCAN
//   (window read one digit a cycle) and DRAIN, both skipped for an empty window, and ACC;
//   DONE registers the result; the input stalls till then and while an older one is held.
// Reset (rst_n low, synchronous): line empty, total zero, keep_count 12, no result.
`timescale 1ns / 1ps

module largest_digit_subsequence
  import lds_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF,
  parameter int MAX_KEEP   = MAX_KEEP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lds_in_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output lds_out_t          out_data,
  input  logic              cfg_wr_en,
  input  logic [KEEP_W-1:0] cfg_wr_data
);

  localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
  localparam int ADDR_W = $clog2(LINE_DEPTH);
  localparam int REM_W  = $clog2(MAX_KEEP + 1);
  localparam int CW     = (LEN_W > REM_W) ? LEN_W : REM_W;
  localparam int KC_W   = (KEEP_W > REM_W) ? KEEP_W : REM_W;
  localparam int DEC_W  = dec_bits(MAX_KEEP);
  localparam int ACC_W  = (DEC_W > VALUE_W) ? DEC_W : VALUE_W;
  localparam int SUM_W  = ((ACC_W > TOTAL_W) ? ACC_W : TOTAL_W) + 1;

  lds_state_t state_r, state_nxt;

  logic [KEEP_W-1:0]  keep_r;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               ovf_r, ovf_nxt;
  logic [LEN_W-1:0]   start_r, start_nxt;
  logic [LEN_W-1:0]   end_r, end_nxt;
  logic [LEN_W-1:0]   idx_r, idx_nxt;
  logic [LEN_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic               pend_r, pend_nxt;
  logic [LEN_W-1:0]   at_r, at_nxt;
  logic [DIGIT_W-1:0] best_r, best_nxt;
  logic               found_r, found_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [ACC_W-1:0]   val_r, val_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  lds_out_t           out_data_r, out_data_nxt;

  logic [DIGIT_W-1:0] digit_mem_r [LINE_DEPTH];
  logic [DIGIT_W-1:0] mem_rd_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [DIGIT_W-1:0] mem_wd;
  logic [ADDR_W-1:0]  mem_ra;

  logic               in_acc;
  logic               out_free;
  logic [KC_W-1:0]    kc_ext;
  logic [REM_W-1:0]   keep_eff;
  logic [REM_W-1:0]   rest;
  logic [CW-1:0]      len_cw;
  logic [CW-1:0]      rest_cw;
  logic [CW-1:0]      win_end_cw;
  logic [LEN_W-1:0]   win_end;
  logic               win_ok;
  logic [SUM_W-1:0]   sum;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // keep_count of 0 acts as 1, above MAX_KEEP acts as MAX_KEEP
  always_comb begin
    kc_ext = KC_W'(keep_r);
    if (kc_ext == '0) begin
      keep_eff = REM_W'(1);
    end else if (kc_ext > KC_W'(MAX_KEEP)) begin
      keep_eff = REM_W'(MAX_KEEP);
    end else begin
      keep_eff = REM_W'(kc_ext);
    end
  end

  // window for the current position: [start, len - rest)
  assign rest       = rem_r - REM_W'(1);
  assign len_cw     = CW'(len_r);
  assign rest_cw    = CW'(rest);
  assign win_end_cw = len_cw - rest_cw;
  assign win_end    = LEN_W'(win_end_cw);
  assign win_ok     = (len_cw > rest_cw) && (start_r < win_end);

  assign sum = SUM_W'(total_r) + SUM_W'(val_r);

  // line memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem_r[mem_wa] <= mem_wd;
    end
    mem_rd_r <= digit_mem_r[mem_ra];
  end

  assign mem_we = in_acc && (len_r < LEN_W'(LINE_DEPTH));
  assign mem_wa = len_r[ADDR_W-1:0];
  assign mem_wd = (in_data.digit > DIGIT_MAX) ? DIGIT_MAX : in_data.digit;
  assign mem_ra = idx_r[ADDR_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.last_digit) state_nxt = ST_POS;
      end
      ST_POS: begin
        state_nxt = win_ok ? ST_SCAN : ST_ACC;
      end
      ST_SCAN: begin
        if (idx_r + LEN_W'(1) == end_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        state_nxt = (rem_r == REM_W'(1)) ? ST_DONE : ST_POS;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    idx_nxt       = idx_r;
    pend_idx_nxt  = pend_idx_r;
    pend_nxt      = 1'b0;
    at_nxt        = at_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    rem_nxt       = rem_r;
    val_nxt       = val_r;
    total_nxt     = total_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    // compare the digit read in the previous cycle; first maximum wins
    if (pend_r && (!found_r || mem_rd_r > best_r)) begin
      best_nxt  = mem_rd_r;
      at_nxt    = pend_idx_r;
      found_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (mem_we) begin
            len_nxt = len_r + LEN_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_digit) begin
            start_nxt = '0;
            rem_nxt   = keep_eff;
            val_nxt   = '0;
          end
        end
      end
      ST_POS: begin
        found_nxt = 1'b0;
        best_nxt  = '0;
        idx_nxt   = start_r;
        end_nxt   = win_end;
      end
      ST_SCAN: begin
        pend_nxt     = 1'b1;
        pend_idx_nxt = idx_r;
        idx_nxt      = idx_r + LEN_W'(1);
      end
      ST_DRAIN: begin
      end
      ST_ACC: begin
        // value * 10 + digit by shift and add
        val_nxt = (val_r << 3) + (val_r << 1) + ACC_W'(best_r);
        if (found_r) start_nxt = at_r + LEN_W'(1);
        rem_nxt = rem_r - REM_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          if (sum > SUM_W'({TOTAL_W{1'b1}})) begin
            total_nxt = {TOTAL_W{1'b1}};
          end else begin
            total_nxt = sum[TOTAL_W-1:0];
          end
          out_data_nxt.best_value    = val_r[VALUE_W-1:0];
          out_data_nxt.running_total = total_nxt;
          out_data_nxt.line_overflow = ovf_r;
          out_valid_nxt = 1'b1;
          len_nxt       = '0;
          ovf_nxt       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      keep_r      <= KEEP_RESET;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) keep_r <= cfg_wr_data;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    at_r       <= at_nxt;
    best_r     <= best_nxt;
    found_r    <= found_nxt;
    rem_r      <= rem_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> hdl/lds_checker.sv
// Port-level checker for the largest digit subsequence block, with its bind
`timescale 1ns / 1ps

`include "largest_digit_subsequence_assert.svh"

module lds_checker
  import lds_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input lds_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input lds_out_t out_data
);

  // a line end starts the selection, which holds off further requests
  `LDS_ASSERT(a_last_stalls, (in_valid && !in_stall && in_data.last_digit) |=> in_stall, "line end did not start selection")

  // mid-line digits are loaded back to back
  `LDS_ASSERT(a_mid_no_stall, (in_valid && !in_stall && !in_data.last_digit) |=> !in_stall, "mid-line digit stalled the next request")

  // the total already includes the value shown with it
  `LDS_ASSERT(a_total_covers, out_valid |-> (out_data.running_total >= out_data.best_value), "running total below best value")

  `LDS_ASSERT(a_out_held, (out_valid && out_stall) |=> out_valid, "stalled result dropped")

  `LDS_ASSERT_RST(a_reset_idle, !rst_n |=> (!in_stall && !out_valid), "block not idle after reset")

endmodule

bind largest_digit_subsequence lds_checker u_lds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> verif/largest_digit_subsequence_tb.sv
// Self-checking testbench for the largest digit subsequence block
`timescale 1ns / 1ps

module largest_digit_subsequence_tb;
  import lds_pkg::*;

  localparam int LINE_SLOTS    = LINE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 50;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int RANDOM_DIGITS = 1300;
  localparam int MAX_LINES     = 25;
  localparam int PRINT_LIMIT   = 50;
  localparam logic [TOTAL_W-1:0] TOTAL_CAP = '1;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  lds_in_t           in_data;
  logic              out_valid;
  logic              out_stall;
  lds_out_t          out_data;
  logic              cfg_wr_en;
  logic [KEEP_W-1:0] cfg_wr_data;

  // requests waiting to be sent and results waiting to be seen
  lds_in_t  digit_queue[$];
  lds_out_t line_results[$];

  // predictor state
  logic [DIGIT_W-1:0] line_mem [LINE_SLOTS];
  int                 line_cnt = 0;
  logic [TOTAL_W-1:0] sum_acc  = '0;
  logic               dropped  = 1'b0;
  logic [KEEP_W-1:0]  keep_sel = KEEP_RESET;

  int errors    = 0;
  int cycles    = 0;
  bit quiet     = 1'b0;
  bit in_took   = 1'b0;
  bit out_took  = 1'b0;
  int send_wait = 0;
  int recv_wait = 0;

  largest_digit_subsequence i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  function automatic int idle_draw();
    return quiet ? 0 : int'($urandom_range(9, 0));
  endfunction

  // greedy pick: first maximum in each window that leaves room for the rest
  function automatic logic [VALUE_W-1:0] largest_pick(int len, int k);
    logic [63:0]        acc;
    logic [DIGIT_W-1:0] top;
    int                 start;
    int                 rest;
    int                 at;
    bit                 found;
    acc   = '0;
    start = 0;
    for (int p = 0; p < k; p++) begin
      rest  = k - 1 - p;
      top   = '0;
      found = 1'b0;
      at    = start;
      // empty window leaves a leading zero and keeps the start
      if (len > rest) begin
        for (int j = start; j < len - rest; j++) begin
          if (!found || line_mem[j] > top) begin
            top   = line_mem[j];
            at    = j;
            found = 1'b1;
          end
        end
      end
      if (found) start = at + 1;
      acc = acc * 10 + 64'(top);
    end
    return acc[VALUE_W-1:0];
  endfunction

  task automatic absorb_digit(lds_in_t item);
    logic [DIGIT_W-1:0] d;
    logic [63:0]        val;
    int                 k;
    lds_out_t           res;
    d = (item.digit > DIGIT_MAX) ? DIGIT_MAX : item.digit;
    if (line_cnt < LINE_SLOTS) begin
      line_mem[line_cnt] = d;
      line_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (item.last_digit) begin
      k = int'(keep_sel);
      if (k < 1) k = 1;
      if (k > MAX_KEEP_DEF) k = MAX_KEEP_DEF;
      val = 64'(largest_pick(line_cnt, k));
      if (val > 64'(TOTAL_CAP) - 64'(sum_acc)) sum_acc = TOTAL_CAP;
      else sum_acc = sum_acc + val[TOTAL_W-1:0];
      res.best_value    = val[VALUE_W-1:0];
      res.running_total = sum_acc;
      res.line_overflow = dropped;
      line_results.push_back(res);
      line_cnt = 0;
      dropped  = 1'b0;
    end
  endtask

  task automatic report_mismatch(string msg);
    if (errors < PRINT_LIMIT) $display("cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic push_digit(int d, bit last);
    lds_in_t it;
    it.digit      = DIGIT_W'(d);
    it.last_digit = last;
    digit_queue.push_back(it);
  endtask

  task automatic queue_line(int len, int lo, int hi);
    int d;
    for (int i = 0; i < len; i++) begin
      d = $urandom_range(hi, lo);
      if ($urandom_range(19, 0) == 0) d = $urandom_range(15, 10);
      push_digit(d, i == len - 1);
    end
  endtask

  // wait until every request went out and every result came back
  task automatic settle();
    while (digit_queue.size() != 0 || in_valid || line_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_keep(logic [KEEP_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    keep_sel = v;
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_wait > 0) begin
        in_valid <= 1'b0;
        send_wait--;
      end else if (digit_queue.size() != 0) begin
        in_data   <= digit_queue.pop_front();
        in_valid  <= 1'b1;
        send_wait = idle_draw();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_took) recv_wait = idle_draw();
      if (!out_valid) begin
        out_stall <= quiet ? 1'b0 : 1'($urandom_range(1, 0));
      end else if (recv_wait > 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: predicts on accepted requests, checks accepted results
  always @(posedge clk) begin
    lds_out_t want;
    in_took  <= rst_n && in_valid && !in_stall;
    out_took <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) absorb_digit(in_data);
    if (rst_n && out_valid && !out_stall) begin
      if (line_results.size() == 0) begin
        report_mismatch($sformatf("result with none pending, best_value %0d",
                                  out_data.best_value));
      end else begin
        want = line_results.pop_front();
        if (out_data.best_value !== want.best_value)
          report_mismatch($sformatf("best_value %0d, want %0d",
                                    out_data.best_value, want.best_value));
        if (out_data.running_total !== want.running_total)
          report_mismatch($sformatf("running_total %0d, want %0d",
                                    out_data.running_total, want.running_total));
        if (out_data.line_overflow !== want.line_overflow)
          report_mismatch($sformatf("line_overflow %0b, want %0b",
                                    out_data.line_overflow, want.line_overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int rand_items;
    int n_lines;
    int len;
    int lo;
    int hi;
    int sel;
    logic [KEEP_W-1:0] kv;
    rand_items = 0;
    while (rst_n !== 1'b1) @(posedge clk);

    // directed: reset keep count, a one-digit line above nine, then a full line
    push_digit(15, 1'b1);
    for (int i = 0; i < 12; i++) push_digit(i < 10 ? i : (i == 10 ? 12 : 0), i == 11);
    settle();
    // single kept digit with tied maxima
    set_keep(KEEP_W'(1));
    push_digit(3, 1'b0);
    push_digit(0, 1'b0);
    push_digit(7, 1'b0);
    push_digit(7, 1'b1);
    settle();
    // zero keep count acts as one; all zeros
    set_keep(KEEP_W'(0));
    push_digit(0, 1'b0);
    push_digit(0, 1'b1);
    settle();
    // keep count above the max, short line
    set_keep(KEEP_W'(15));
    push_digit(9, 1'b0);
    push_digit(9, 1'b0);
    push_digit(9, 1'b1);
    settle();

    while (rand_items < RANDOM_DIGITS) begin
      sel = $urandom_range(7, 0);
      case (sel)
        0:       kv = 4'd0;
        1:       kv = 4'd1;
        2:       kv = 4'd12;
        3:       kv = 4'd15;
        4:       kv = 4'd13;
        default: kv = KEEP_W'($urandom_range(12, 1));
      endcase
      set_keep(kv);
      quiet   = ($urandom_range(3, 0) == 0);
      n_lines = $urandom_range(15, 5);
      for (int l = 0; l < n_lines; l++) begin
        sel = $urandom_range(99, 0);
        if (sel < 3) len = $urandom_range(140, 126);
        else if (sel < 25) len = $urandom_range(13, 1);
        else len = $urandom_range(40, 12);
        // narrow alphabets give many ties
        if ($urandom_range(3, 0) == 0) begin
          lo = $urandom_range(8, 0);
          hi = lo + 1;
        end else begin
          lo = 0;
          hi = 9;
        end
        queue_line(len, lo, hi);
        rand_items += len;
      end
      settle();
    end

    // lines of nines at the full keep count give the widest values
    set_keep(KEEP_W'(12));
    quiet = 1'b0;
    for (int l = 0; l < MAX_LINES; l++) queue_line(12, 9, 15);
    settle();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
